// ===== rtl/core/ued_pkg.sv =====
// Package for the unique-entry deque: request and status codes, cell command type.
// No dependencies.
package ued_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int KEY_BITS_DEF = 17;
	localparam int OP_BITS      = 2;
	localparam int STATUS_BITS  = 2;

	typedef enum logic [OP_BITS-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
	} cell_cmd_t;

endpackage

// ===== rtl/core/ued_cell.sv =====
// One storage cell of the deque: holds the key at position IDX from the front.
// Depends on ued_pkg.
module ued_cell #(
	parameter int IDX      = 0,
	parameter int KEY_BITS = ued_pkg::KEY_BITS_DEF,
	parameter int CNT_W    = 5
) (
	input  logic                 clk,
	input  ued_pkg::cell_cmd_t   cmd,
	input  logic [CNT_W-1:0]     cnt,
	input  logic [KEY_BITS-1:0]  probe_key,
	input  logic [KEY_BITS-1:0]  left_key,
	input  logic [KEY_BITS-1:0]  right_key,
	output logic [KEY_BITS-1:0]  key,
	output logic                 match,
	output logic [KEY_BITS-1:0]  last_key
);
	import ued_pkg::*;

	logic [KEY_BITS-1:0] key_q;
	logic                occ;
	logic                at_tail;
	logic                is_last;

	assign occ     = cnt > CNT_W'(IDX);
	assign at_tail = cnt == CNT_W'(IDX);
	assign is_last = cnt == CNT_W'(IDX + 1);

	assign key      = key_q;
	assign match    = occ && (key_q == probe_key);
	assign last_key = is_last ? key_q : '0;

	always_ff @(posedge clk) begin
		priority if (cmd.push_front) begin
			key_q <= left_key;
		end else if (cmd.pop_front) begin
			key_q <= right_key;
		end else if (cmd.push_back && at_tail) begin
			key_q <= probe_key;
		end
	end

endmodule

// ===== rtl/core/unique_entry_deque_unit.sv =====
// Deque of unique keys held in a row of shifting cells; each request gets one status word.
// Depends on ued_pkg and ued_cell.
//
// One request word is taken per clock cycle; its result word appears in the output register
// in the cycle after acceptance. Every cell compares its key with the request key in the same
// cycle, so the duplicate check, push and pop at either end all finish in that same cycle;
// the input stalls only while a result word waits in the output register.
module unique_entry_deque_unit #(
	parameter int DEPTH    = ued_pkg::DEPTH_DEF,
	parameter int KEY_BITS = ued_pkg::KEY_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ued_pkg::OP_BITS-1:0]       opcode,
	input  logic [KEY_BITS-1:0]               entry_key,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ued_pkg::STATUS_BITS-1:0]   status,
	output logic [KEY_BITS-1:0]               popped_key,
	output logic [$clog2(DEPTH+1)-1:0]        occupancy
);
	import ued_pkg::*;

	localparam int CNT_W = $clog2(DEPTH+1);

	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_d;
	logic                out_valid_q;
	status_t             status_q;
	logic [KEY_BITS-1:0] popped_q;
	logic [CNT_W-1:0]    occ_q;

	logic [KEY_BITS-1:0] cell_key  [DEPTH];
	logic [KEY_BITS-1:0] cell_last [DEPTH];
	logic [DEPTH-1:0]    cell_match;

	logic                accept;
	logic                dup;
	logic                full;
	logic                empty;
	logic [KEY_BITS-1:0] back_key;
	cell_cmd_t           cmd;
	status_t             status_d;
	logic [KEY_BITS-1:0] popped_d;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign dup   = |cell_match;
	assign full  = cnt_q == CNT_W'(DEPTH);
	assign empty = cnt_q == '0;

	always_comb begin
		back_key = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_key = back_key | cell_last[i];
		end
	end

	always_comb begin
		cmd      = '0;
		status_d = ST_OK;
		popped_d = '0;
		cnt_d    = cnt_q;
		unique case (op_t'(opcode))
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				priority if (dup) begin
					status_d = ST_DUP;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.push_front = accept && (op_t'(opcode) == OP_PUSH_FRONT);
					cmd.push_back  = accept && (op_t'(opcode) == OP_PUSH_BACK);
					cnt_d          = cnt_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					cmd.pop_front = accept;
					popped_d      = cell_key[0];
					cnt_d         = cnt_q - CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					popped_d = back_key;
					cnt_d    = cnt_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_BITS-1:0] left_key;
		logic [KEY_BITS-1:0] right_key;
		if (i == 0) begin : g_first
			assign left_key = entry_key;
		end else begin : g_mid_l
			assign left_key = cell_key[i-1];
		end
		if (i == DEPTH-1) begin : g_last
			assign right_key = cell_key[i];
		end else begin : g_mid_r
			assign right_key = cell_key[i+1];
		end
		ued_cell #(
			.IDX      (i),
			.KEY_BITS (KEY_BITS),
			.CNT_W    (CNT_W)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.cnt       (cnt_q),
			.probe_key (entry_key),
			.left_key  (left_key),
			.right_key (right_key),
			.key       (cell_key[i]),
			.match     (cell_match[i]),
			.last_key  (cell_last[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			popped_q <= popped_d;
			occ_q    <= cnt_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign popped_key = popped_q;
	assign occupancy  = occ_q;

endmodule

// ===== rtl/core/ued_checker.sv =====
// Port-level checks for unique_entry_deque_unit, attached by bind.
// Depends on ued_pkg.
module ued_checker #(
	parameter int DEPTH    = ued_pkg::DEPTH_DEF,
	parameter int KEY_BITS = ued_pkg::KEY_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [ued_pkg::STATUS_BITS-1:0]   status,
	input logic [KEY_BITS-1:0]               popped_key,
	input logic [$clog2(DEPTH+1)-1:0]        occupancy
);
	import ued_pkg::*;

	localparam int CNT_W = $clog2(DEPTH+1);

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= CNT_W'(DEPTH))
		else $error("occupancy above depth");

	a_no_pop_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> popped_key == '0)
		else $error("key reported on a failed request");

	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY || status == ST_FULL) |->
		occupancy == (status == ST_EMPTY ? CNT_W'(0) : CNT_W'(DEPTH)))
		else $error("empty or full status with wrong occupancy");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(popped_key) && $stable(occupancy))
		else $error("stalled result word changed");

endmodule

bind unique_entry_deque_unit ued_checker #(
	.DEPTH    (DEPTH),
	.KEY_BITS (KEY_BITS)
) u_ued_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.popped_key (popped_key),
	.occupancy  (occupancy)
);

// ===== tb/unique_entry_deque_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for unique_entry_deque_unit: directed table, then random requests.
// Every result word is compared with its typed-in expectation or a deque predictor kept in the testbench.
// Depends on ued_pkg and the deque RTL.
module unique_entry_deque_unit_tb;
	import ued_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int KEY_BITS   = KEY_BITS_DEF;
	localparam int OCC_BITS   = $clog2(DEPTH + 1);
	localparam int DIR_ROWS   = 25;
	localparam int RAND_WORDS = 1825;
	localparam int POOL_SIZE  = 24;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_START = 1500;
	localparam int HOLD_LEN   = 400;

	typedef logic [KEY_BITS-1:0] key_t;

	typedef struct packed {
		status_t             status;
		key_t                popped;
		logic [OCC_BITS-1:0] occ;
	} result_t;

	typedef struct {
		op_t     op;
		key_t    key;
		bit      typed;
		result_t result;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [OP_BITS-1:0]     opcode = OP_PUSH_FRONT;
	logic [KEY_BITS-1:0]    entry_key = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [STATUS_BITS-1:0] status;
	logic [KEY_BITS-1:0]    popped_key;
	logic [OCC_BITS-1:0]    occupancy;

	// typed-in expectation travels with the word, driven like the payload
	bit      row_typed = 1'b0;
	result_t row_result = '0;

	key_t     deque_model[$];
	result_t  awaited_results[$];
	key_t     key_pool[POOL_SIZE];
	dir_row_t dir_rows[DIR_ROWS];
	int       mismatch_count = 0;
	int       idle_cycles = 0;
	result_t  predicted;
	result_t  expected;

	unique_entry_deque_unit #(
		.DEPTH(DEPTH),
		.KEY_BITS(KEY_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.entry_key(entry_key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.popped_key(popped_key),
		.occupancy(occupancy)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic result_t apply_request(op_t op, key_t key);
		result_t r;
		bit      dup;
		r = '0;
		r.status = ST_OK;
		dup = 1'b0;
		foreach (deque_model[i])
			if (deque_model[i] == key)
				dup = 1'b1;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (dup)
					r.status = ST_DUP;
				else if (deque_model.size() >= DEPTH)
					r.status = ST_FULL;
				else if (op == OP_PUSH_FRONT)
					deque_model.push_front(key);
				else
					deque_model.push_back(key);
			end
			default: begin
				if (deque_model.size() == 0)
					r.status = ST_EMPTY;
				else if (op == OP_POP_FRONT)
					r.popped = deque_model.pop_front();
				else
					r.popped = deque_model.pop_back();
			end
		endcase
		r.occ = OCC_BITS'(deque_model.size());
		return r;
	endfunction

	function automatic key_t pick_key();
		if ($urandom_range(0, 9) < 7)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return key_t'($urandom);
	endfunction

	task automatic send_word(input op_t op, input key_t key, input bit typed,
			input result_t result);
		in_valid <= 1'b1;
		opcode <= op;
		entry_key <= key;
		row_typed <= typed;
		row_result <= result;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// scoreboard: result side first, then the newly accepted request
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result word status %0d popped %h occ %0d",
							$realtime, status, popped_key, occupancy);
				end else begin
					expected = awaited_results.pop_front();
					if (status !== expected.status || popped_key !== expected.popped ||
							occupancy !== expected.occ) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch exp %0d/%h/%0d got %0d/%h/%0d",
								$realtime, expected.status, expected.popped, expected.occ,
								status, popped_key, occupancy);
					end
				end
			end
			if (in_valid && !in_stall) begin
				predicted = apply_request(op_t'(opcode), entry_key);
				awaited_results.push_back(row_typed ? row_result : predicted);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: rotating stall patterns plus one long hold-off
	initial begin
		int cyc;
		int mode;
		cyc = 0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			if (cyc == HOLD_START) begin
				out_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
			end
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 7) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 1);
				default: out_stall <= (cyc % 3 == 0);
			endcase
		end
	end

	initial begin
		int      sent;
		int      burst;
		int      gap;
		int      push_pct;
		op_t     op;
		key_t    fill_key;
		result_t blank;

		blank = '0;
		foreach (key_pool[i])
			key_pool[i] = key_t'($urandom);
		key_pool[0] = '0;
		key_pool[1] = '1;

		dir_rows[0] = '{OP_POP_FRONT, '1, 1'b1, '{ST_EMPTY, '0, 5'd0}};
		dir_rows[1] = '{OP_POP_BACK, '0, 1'b1, '{ST_EMPTY, '0, 5'd0}};
		dir_rows[2] = '{OP_PUSH_FRONT, '0, 1'b1, '{ST_OK, '0, 5'd1}};
		dir_rows[3] = '{OP_PUSH_BACK, '1, 1'b1, '{ST_OK, '0, 5'd2}};
		dir_rows[4] = '{OP_PUSH_BACK, '0, 1'b1, '{ST_DUP, '0, 5'd2}};
		dir_rows[5] = '{OP_POP_BACK, '0, 1'b1, '{ST_OK, '1, 5'd1}};
		dir_rows[6] = '{OP_POP_FRONT, '1, 1'b1, '{ST_OK, '0, 5'd0}};
		for (int i = 0; i < DEPTH; i++) begin
			fill_key = (i % 2 == 0) ? key_t'(17'h0AAAA ^ i) : key_t'(17'h15555 ^ i);
			dir_rows[7 + i] = '{(i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, fill_key,
				1'b0, blank};
		end
		// full queue: new key is refused as full, held key still reads as duplicate
		dir_rows[23] = '{OP_PUSH_BACK, '1, 1'b1, '{ST_FULL, '0, 5'd16}};
		dir_rows[24] = '{OP_PUSH_FRONT, 17'h0AAAA, 1'b1, '{ST_DUP, '0, 5'd16}};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].result);

		sent = 0;
		push_pct = 50;
		while (sent < RAND_WORDS) begin
			burst = $urandom_range(1, 32);
			for (int b = 0; b < burst && sent < RAND_WORDS; b++) begin
				if (sent % 40 == 0) begin
					case ($urandom_range(0, 2))
						0: push_pct = 80;
						1: push_pct = 50;
						default: push_pct = 20;
					endcase
				end
				if (sent % 97 == 0)
					key_pool[$urandom_range(2, POOL_SIZE - 1)] = key_t'($urandom);
				if ($urandom_range(0, 99) < push_pct)
					op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
				else
					op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
				send_word(op, pick_key(), 1'b0, blank);
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ued_pkg.sv
rtl/core/ued_cell.sv
rtl/core/unique_entry_deque_unit.sv
rtl/core/ued_checker.sv
tb/unique_entry_deque_unit_tb.sv
